>>> rtl/core/i2cbb_pkg.sv
// shared types and constants for the i2c byte-level master sequencer
package i2cbb_pkg;

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_SEND_ACK = 3'd4,
        OP_READ_ACK = 3'd5
    } op_t;

    // one queued bus command
    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       ack_to_send;
        logic [7:0] partner_byte;
        logic       partner_ack;
    } cmd_t;

    localparam logic [15:0] HOLD_RESET = 16'd1000;
    localparam logic [7:0]  BIT_MSB    = 8'h80;

endpackage

>>> rtl/core/i2c_bitbang_master_sequencer_unit.sv
// top level of the i2c byte-level master sequencer
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  in       | in_valid / in_ready    | op, data_byte, ack_to_send, partner_byte,
//           |                        | partner_ack
//  out      | out_valid / out_ready  | scl_level, sda_level, sample_taken, read_value,
//           |                        | ack_seen, last
//  cfg      | cfg_valid / cfg_ready  | cfg_data (hold_cycles)
//
// each line step is one pass through ST_STEP, then ST_HOLD while the hold counter counts down
// from hold_cycles and the out channel takes the step; a command is first fetched from
// the queue in ST_IDLE; a write byte steps through data, scl high and scl low for each bit
// the hold counter in the line sequencer sets the pace; intake runs ahead through the
// command queue, which takes QUEUE_DEPTH commands while the sequencer is busy
// reset clears the line levels and the ack bit to 0 and the hold time to 1000
// a stalled out channel freezes the sequencer once the current hold has run out
module i2c_bitbang_master_sequencer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        ack_to_send,
    input  logic [7:0]  partner_byte,
    input  logic        partner_ack,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_level,
    output logic        sample_taken,
    output logic [7:0]  read_value,
    output logic        ack_seen,
    output logic        last
);
    import i2cbb_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_push_data;
    logic q_pop;
    logic q_valid;
    cmd_t q_data;

    assign cfg_ready = 1'b1;

    i2cbb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .data_byte    (data_byte),
        .ack_to_send  (ack_to_send),
        .partner_byte (partner_byte),
        .partner_ack  (partner_ack),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_data  (q_push_data)
    );

    i2cbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    i2cbb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .sample_taken (sample_taken),
        .read_value   (read_value),
        .ack_seen     (ack_seen),
        .last         (last)
    );

endmodule

>>> rtl/core/i2cbb_front.sv
// command intake: accepts items, drops undefined ops, pushes the rest to the queue
module i2cbb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic [7:0]         data_byte,
    input  logic               ack_to_send,
    input  logic [7:0]         partner_byte,
    input  logic               partner_ack,
    input  logic               q_full,
    output logic               q_push,
    output i2cbb_pkg::cmd_t    q_push_data
);
    import i2cbb_pkg::*;

    logic op_known;
    logic busy_reg;

    assign op_known = (op <= 3'(OP_READ_ACK));

    // ready while the queue has room, once busy_reg has cleared after reset
    assign in_ready = !q_full && !busy_reg;
    assign q_push   = in_valid && in_ready && op_known;

    always_comb
    begin
        q_push_data.op           = op_t'(op);
        q_push_data.data_byte    = data_byte;
        q_push_data.ack_to_send  = ack_to_send;
        q_push_data.partner_byte = partner_byte;
        q_push_data.partner_ack  = partner_ack;
    end

    // held in reset so nothing is taken before the back end is running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/core/i2cbb_queue.sv
// small command fifo between intake and line sequencer
module i2cbb_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cbb_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output i2cbb_pkg::cmd_t pop_data
);
    import i2cbb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/i2cbb_back.sv
// line sequencer: steps scl/sda through each command and times every level
module i2cbb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic [15:0]     cfg_data,
    input  logic            q_valid,
    input  i2cbb_pkg::cmd_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            scl_level,
    output logic            sda_level,
    output logic            sample_taken,
    output logic [7:0]      read_value,
    output logic            ack_seen,
    output logic            last
);
    import i2cbb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_HOLD
    } state_t;

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [1:0]  ph_reg;
    logic [2:0]  bit_reg;
    logic [7:0]  acc_reg;
    logic        scl_reg;
    logic        sda_reg;
    logic        ack_reg;
    logic [15:0] hold_reg;
    logic [15:0] cnt_reg;
    logic        out_valid_reg;
    logic        scl_out_reg;
    logic        sda_out_reg;
    logic        sample_reg;
    logic [7:0]  rv_reg;
    logic        ack_out_reg;
    logic        last_reg;

    logic [7:0]  mask;
    logic [1:0]  ph_next;
    logic [2:0]  bit_next;
    logic [7:0]  acc_next;
    logic        scl_next;
    logic        sda_next;
    logic        ack_next;
    logic        sample_next;
    logic [7:0]  rv_next;
    logic        fin_next;
    logic        step_go;

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    // level held long enough and the previous transaction is out of the way
    assign step_go = (cnt_reg <= 16'd1) && (!out_valid_reg || out_ready);

    always_comb
    begin
        mask        = BIT_MSB >> bit_reg;
        ph_next     = ph_reg + 2'd1;
        bit_next    = bit_reg;
        acc_next    = acc_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        ack_next    = ack_reg;
        sample_next = 1'b0;
        rv_next     = 8'd0;
        fin_next    = 1'b0;
        unique case (cmd_reg.op)
            OP_START:
            begin
                unique case (ph_reg)
                    2'd0: sda_next = 1'b1;
                    2'd1: scl_next = 1'b1;
                    2'd2: sda_next = 1'b0;
                    default:
                    begin
                        scl_next = 1'b0;
                        fin_next = 1'b1;
                    end
                endcase
            end
            OP_STOP:
            begin
                unique case (ph_reg)
                    2'd0: sda_next = 1'b0;
                    2'd1: scl_next = 1'b1;
                    default:
                    begin
                        sda_next = 1'b1;
                        fin_next = 1'b1;
                    end
                endcase
            end
            OP_WRITE:
            begin
                unique case (ph_reg)
                    2'd0: sda_next = |(cmd_reg.data_byte & mask);
                    2'd1: scl_next = 1'b1;
                    default:
                    begin
                        scl_next = 1'b0;
                        fin_next = (bit_reg == 3'd7);
                        ph_next  = 2'd0;
                        bit_next = bit_reg + 3'd1;
                    end
                endcase
            end
            OP_READ:
            begin
                unique case (ph_reg)
                    2'd0: sda_next = 1'b1;
                    2'd1:
                    begin
                        scl_next    = 1'b1;
                        sample_next = 1'b1;
                        acc_next    = acc_reg | (cmd_reg.partner_byte & mask);
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        fin_next = (bit_reg == 3'd7);
                        // preamble step only once, then sample/low pairs
                        ph_next  = 2'd1;
                        bit_next = bit_reg + 3'd1;
                    end
                endcase
                rv_next = acc_next;
            end
            OP_SEND_ACK:
            begin
                unique case (ph_reg)
                    2'd0: sda_next = cmd_reg.ack_to_send;
                    2'd1: scl_next = 1'b1;
                    default:
                    begin
                        scl_next = 1'b0;
                        fin_next = 1'b1;
                    end
                endcase
            end
            OP_READ_ACK:
            begin
                unique case (ph_reg)
                    2'd0: sda_next = 1'b1;
                    2'd1:
                    begin
                        scl_next    = 1'b1;
                        sample_next = 1'b1;
                        ack_next    = cmd_reg.partner_ack;
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        fin_next = 1'b1;
                    end
                endcase
            end
            default: fin_next = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            ph_reg        <= '0;
            bit_reg       <= '0;
            acc_reg       <= '0;
            scl_reg       <= 1'b0;
            sda_reg       <= 1'b0;
            ack_reg       <= 1'b0;
            hold_reg      <= HOLD_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            scl_out_reg   <= 1'b0;
            sda_out_reg   <= 1'b0;
            sample_reg    <= 1'b0;
            rv_reg        <= '0;
            ack_out_reg   <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                hold_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_data;
                        ph_reg    <= '0;
                        bit_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    ph_reg        <= ph_next;
                    bit_reg       <= bit_next;
                    acc_reg       <= acc_next;
                    scl_reg       <= scl_next;
                    sda_reg       <= sda_next;
                    ack_reg       <= ack_next;
                    scl_out_reg   <= scl_next;
                    sda_out_reg   <= sda_next;
                    sample_reg    <= sample_next;
                    rv_reg        <= rv_next;
                    ack_out_reg   <= ack_next;
                    last_reg      <= fin_next;
                    out_valid_reg <= 1'b1;
                    cnt_reg       <= hold_reg;
                    state_reg     <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (cnt_reg > 16'd1)
                    begin
                        cnt_reg <= cnt_reg - 16'd1;
                    end
                    if (step_go)
                    begin
                        state_reg <= last_reg ? ST_IDLE : ST_STEP;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_level    = scl_out_reg;
    assign sda_level    = sda_out_reg;
    assign sample_taken = sample_reg;
    assign read_value   = rv_reg;
    assign ack_seen     = ack_out_reg;
    assign last         = last_reg;

endmodule

>>> rtl/core/i2cbb_checker.sv
// port-level checks for the i2c sequencer, bound to the top level
module i2cbb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       scl_level,
    input logic       sda_level,
    input logic       sample_taken,
    input logic [7:0] read_value,
    input logic       ack_seen,
    input logic       last
);

    // stalled transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scl_level) && $stable(sda_level)
            && $stable(sample_taken) && $stable(read_value) && $stable(ack_seen)
            && $stable(last))
        else $error("out payload changed while stalled");

    // sampling happens with both lines released
    a_sample_lines: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_taken |-> scl_level && sda_level)
        else $error("sample taken with a line driven low");

    // no command ends on a sampling step
    a_last_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !sample_taken)
        else $error("final step marked as a sample");

    // out_valid drops in the cycle after every hand-over, so line steps never go back to back
    a_step_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("line steps issued back to back");

endmodule

bind i2c_bitbang_master_sequencer_unit i2cbb_checker u_i2cbb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scl_level    (scl_level),
    .sda_level    (sda_level),
    .sample_taken (sample_taken),
    .read_value   (read_value),
    .ack_seen     (ack_seen),
    .last         (last)
);
